// ----- design/assert_macros.svh -----
// Assertion macros shared by the sliding window maximum RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SWM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/swm_pkg.sv -----
// Package for the sliding window maximum block: widths, limits and shared types.
// No dependencies; the interfaces and the RTL modules refer to it by scoped names.
package swm_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int POS_BITS    = 16;
  localparam int LEN_BITS    = 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  // One deque entry as held by a cell.
  typedef struct packed {
    sample_t value;
    pos_t    pos;
  } entry_t;

  // Control and data broadcast from the top level to every cell.
  typedef struct packed {
    logic    en;
    logic    clear;
    logic    shift;
    sample_t sample;
    entry_t  fresh;
  } cell_ctrl_t;

endpackage

// ----- design/swm_if.sv -----
// Channel interfaces for the sliding window maximum block.
// Depends on swm_pkg for the payload types.
interface swm_in_if;
  logic                valid;
  logic                ready;
  swm_pkg::sample_t    sample;
  logic                last_sample;
  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

interface swm_out_if;
  logic                valid;
  logic                ready;
  swm_pkg::sample_t    window_max;
  swm_pkg::pos_t       window_end;
  logic                last_window;
  modport source(output valid, window_max, window_end, last_window, input ready);
  modport sink(input valid, window_max, window_end, last_window, output ready);
endinterface

interface swm_cfg_if;
  logic                valid;
  logic                ready;
  swm_pkg::len_t       data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- design/sliding_window_maximum.sv -----
// Sliding window maximum: a row of deque cells updated in parallel per sample.
// Each result is registered in the cycle after its sample transfer; one sample per
// cycle is taken while no result is stalled, set by the single compare-and-shift step
// across the cell row. Reset (synchronous) empties the deque, sets the window length
// to 3 and the position to zero; no clearing pass. Depends on swm_pkg, swm_if, swm_cell.
`include "assert_macros.svh"

module sliding_window_maximum (
  input  logic  clk,
  input  logic  rst,
  swm_cfg_if.sink    cfg,
  swm_in_if.sink     samples,
  swm_out_if.source  results
);

  localparam int N = swm_pkg::MAX_WINDOW;

  swm_pkg::len_t       window_len;
  swm_pkg::pos_t       position;
  logic                wrapped;
  logic                out_valid;
  swm_pkg::sample_t    out_max;
  swm_pkg::pos_t       out_end;
  logic                out_last;

  swm_pkg::cell_ctrl_t ctrl;
  swm_pkg::entry_t     cell_entry [N];
  swm_pkg::entry_t     ext_entry [N+1];
  logic [N-1:0]        valid_bits;
  logic [N-1:0]        surv_bits;
  logic [N:0]          surv_ext;

  logic                accept;
  swm_pkg::pos_t       win_k;
  swm_pkg::pos_t       age;
  logic                shift;
  logic                emit;
  swm_pkg::sample_t    front_value;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !out_valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swm_pkg::len_t'(3);
    end else if (cfg.valid) begin
      window_len <= cfg.data;
    end
  end

  // Clamp the configured length into one to the deque depth.
  always_comb begin
    priority if (window_len == '0) begin
      win_k = swm_pkg::pos_t'(1);
    end else if (swm_pkg::pos_t'(window_len) > swm_pkg::pos_t'(N)) begin
      win_k = swm_pkg::pos_t'(N);
    end else begin
      win_k = swm_pkg::pos_t'(window_len);
    end
  end

  assign age   = position - cell_entry[0].pos;
  // The front leaves when it has aged out, or when the row would overflow.
  assign shift = surv_bits[0] && ((age >= win_k) || surv_bits[N-1]);
  assign emit  = wrapped || ({1'b0, position} + 17'd1 >= {1'b0, win_k});

  assign ctrl.en           = accept;
  assign ctrl.clear        = samples.last_sample;
  assign ctrl.shift        = shift;
  assign ctrl.sample       = samples.sample;
  assign ctrl.fresh.value  = samples.sample;
  assign ctrl.fresh.pos    = position;

  assign surv_ext = {1'b0, surv_bits};

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      assign ext_entry[i] = cell_entry[i];
      swm_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_surv   ((i == 0) ? 1'b1 : surv_ext[(i == 0) ? 0 : i-1]),
        .right_entry (ext_entry[i+1]),
        .right_surv  (surv_ext[i+1]),
        .entry       (cell_entry[i]),
        .valid       (valid_bits[i]),
        .surv        (surv_bits[i])
      );
    end
  endgenerate
  assign ext_entry[N] = ctrl.fresh;

  // Front of the deque after this sample has been applied.
  always_comb begin
    if (shift) begin
      front_value = surv_ext[1] ? ext_entry[1].value : samples.sample;
    end else begin
      front_value = surv_ext[0] ? ext_entry[0].value : samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      wrapped  <= 1'b0;
    end else if (accept) begin
      if (samples.last_sample) begin
        position <= '0;
        wrapped  <= 1'b0;
      end else begin
        position <= position + swm_pkg::pos_t'(1);
        if (position == '1) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_max  <= front_value;
      out_end  <= position;
      out_last <= samples.last_sample;
    end
  end

  assign results.valid       = out_valid;
  assign results.window_max  = out_max;
  assign results.window_end  = out_end;
  assign results.last_window = out_last;

  `SWM_ASSERT_ALWAYS(a_thermometer, ((valid_bits + 1'b1) & valid_bits) == '0)
  `SWM_ASSERT_NEXT(a_last_clears, accept && samples.last_sample, valid_bits == '0)
  `SWM_ASSERT_NEXT(a_emit_shows, accept && emit, results.valid)
  `SWM_ASSERT_SAME(a_stall_blocks, results.valid && !results.ready, !samples.ready)

endmodule

// ----- design/swm_cell.sv -----
// One deque cell: holds a single entry and its valid bit.
// Depends on swm_pkg; instantiated in a row by sliding_window_maximum.
module swm_cell (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::cell_ctrl_t ctrl,
  input  logic                left_surv,
  input  swm_pkg::entry_t     right_entry,
  input  logic                right_surv,
  output swm_pkg::entry_t     entry,
  output logic                valid,
  output logic                surv
);

  logic            valid_next;
  swm_pkg::entry_t entry_next;

  // An entry survives when it is strictly greater than the incoming sample.
  assign surv = valid && (entry.value > ctrl.sample);

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (ctrl.en) begin
      if (ctrl.clear) begin
        valid_next = 1'b0;
      end else if (ctrl.shift) begin
        // The front leaves, so every survivor moves one place towards the front.
        valid_next = right_surv || surv;
        entry_next = right_surv ? right_entry : ctrl.fresh;
      end else begin
        valid_next = surv || left_surv;
        entry_next = surv ? entry : ctrl.fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- tb/sliding_window_maximum_test.sv -----
// Self-checking testbench for sliding_window_maximum: drives samples and window lengths,
// predicts each window maximum and checks every result transfer in order.
// Depends on swm_pkg, the channel interfaces in swm_if and the block itself.
module sliding_window_maximum_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 38;
  localparam int NUM_PHASES    = 12;

  typedef enum int {PAT_SPREAD, PAT_NARROW, PAT_FALLING, PAT_RISING, PAT_EXTREME} pattern_t;

  typedef struct packed {
    swm_pkg::sample_t window_max;
    swm_pkg::pos_t    window_end;
    logic             last_window;
  } window_result_t;

  // Tracks the deque of candidate maxima and queues the window results it implies.
  class window_max_scoreboard;
    swm_pkg::len_t    window_len;
    swm_pkg::sample_t dq_value[swm_pkg::MAX_WINDOW];
    swm_pkg::pos_t    dq_pos[swm_pkg::MAX_WINDOW];
    int unsigned      front;
    int unsigned      count;
    swm_pkg::pos_t    position;
    bit               wrapped;
    window_result_t   expected_windows[$];
    int unsigned      mismatches;
    int unsigned      results_checked;
    int unsigned      samples_noted;

    function new();
      window_len = 3;
      mismatches = 0;
      results_checked = 0;
      samples_noted = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      front = 0;
      count = 0;
      position = '0;
      wrapped = 1'b0;
    endfunction

    function void drop_front();
      front = (front + 1) % swm_pkg::MAX_WINDOW;
      count--;
    endfunction

    function void set_window(swm_pkg::len_t v);
      window_len = v;
    endfunction

    // A length of zero behaves as one, and anything above the deque depth as the depth.
    function int unsigned span();
      if (window_len == 0) return 1;
      if (window_len > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
      return window_len;
    endfunction

    function void note_sample(swm_pkg::sample_t s, logic last);
      int unsigned    k;
      int unsigned    back;
      int unsigned    slot;
      swm_pkg::pos_t  age;
      window_result_t r;
      k = span();
      samples_noted++;
      while (count > 0) begin
        back = (front + count - 1) % swm_pkg::MAX_WINDOW;
        if (dq_value[back] <= s) count--;
        else break;
      end
      if (count > 0) begin
        age = position - dq_pos[front];
        if (age >= k) drop_front();
      end
      if (count >= swm_pkg::MAX_WINDOW) drop_front();
      slot = (front + count) % swm_pkg::MAX_WINDOW;
      dq_value[slot] = s;
      dq_pos[slot] = position;
      count++;
      if (wrapped || int'(position) + 1 >= int'(k)) begin
        r.window_max = dq_value[front];
        r.window_end = position;
        r.last_window = last;
        expected_windows.push_back(r);
      end
      if (position == '1) wrapped = 1'b1;
      position = position + 1'b1;
      if (last) clear_sequence();
    endfunction

    function void report(string what, string want_s, string got_s);
      mismatches++;
      $display("%0t: %s expected %s, actual %s", $time, what, want_s, got_s);
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (expected_windows.size() == 0) begin
        report("result with nothing outstanding", "none",
               $sformatf("max %0d end %0d last %0b",
                         got.window_max, got.window_end, got.last_window));
        return;
      end
      want = expected_windows.pop_front();
      results_checked++;
      if (got.window_max !== want.window_max)
        report("window_max", $sformatf("%0d", want.window_max),
               $sformatf("%0d", got.window_max));
      if (got.window_end !== want.window_end)
        report("window_end", $sformatf("%0d", want.window_end),
               $sformatf("%0d", got.window_end));
      if (got.last_window !== want.last_window)
        report("last_window", $sformatf("%0b", want.last_window),
               $sformatf("%0b", got.last_window));
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   full_rate;
  int   stall_left;
  int   idle_cycles;
  int   settings_used;
  int   sequences_closed;

  swm_cfg_if  cfg_ch ();
  swm_in_if   in_ch ();
  swm_out_if  out_ch ();

  window_max_scoreboard sb;

  sliding_window_maximum dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (in_ch),
    .results (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, short ones mostly, with a rare long one.
  always @(posedge clk) begin
    if (rst || full_rate) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:19]:  stall_left <= $urandom_range(1, 3);
        [20:22]: stall_left <= $urandom_range(10, 30);
        default: stall_left <= 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.window_max, out_ch.window_end, out_ch.last_window});
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called just after a rising edge; returns in the time step of the transfer
  // when no gap follows, so the next sample can keep valid high.
  task automatic send_sample(swm_pkg::sample_t s, logic last);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s, last);
    if (last) sequences_closed++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Samples that leave no result may still be in flight once the queue is empty.
  task automatic write_window(swm_pkg::len_t v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_window(v);
    settings_used++;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic swm_pkg::sample_t next_value(pattern_t pat, ref int level);
    case (pat)
      PAT_SPREAD: return swm_pkg::sample_t'($urandom);
      PAT_NARROW: return swm_pkg::sample_t'(int'($urandom_range(0, 6)) - 3);
      PAT_FALLING: begin
        level = level - int'($urandom_range(0, 400));
        if (level < -32768) level = 32767;
        return swm_pkg::sample_t'(level);
      end
      PAT_RISING: begin
        level = level + int'($urandom_range(0, 400));
        if (level > 32767) level = -32768;
        return swm_pkg::sample_t'(level);
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return swm_pkg::sample_t'(-32768);
          1:       return swm_pkg::sample_t'(32767);
          2:       return swm_pkg::sample_t'(-1);
          3:       return swm_pkg::sample_t'(1);
          default: return swm_pkg::sample_t'(0);
        endcase
      end
    endcase
  endfunction

  // Sequences mostly span a few windows; some end before the window fills.
  task automatic run_phase(int n_items, bit close_last, bit pause_midway);
    int       left;
    int       seq_len;
    int       level;
    int       r;
    int       k;
    pattern_t pat;
    bit       ends;
    left = n_items;
    while (left > 0) begin
      k = sb.span();
      r = $urandom_range(0, 99);
      if (r < 70) seq_len = $urandom_range(k, 3 * k + 8);
      else if (r < 90) seq_len = $urandom_range(1, k);
      else seq_len = 1;
      ends = 1'b1;
      if (seq_len >= left) begin
        seq_len = left;
        ends = close_last;
      end
      pat = pattern_t'($urandom_range(0, 4));
      level = int'(swm_pkg::sample_t'($urandom));
      for (int i = 0; i < seq_len; i++) begin
        send_sample(next_value(pat, level), ends && (i == seq_len - 1));
        left--;
        if (pause_midway && left == n_items / 2) drain();
      end
    end
  endtask

  initial begin
    swm_pkg::len_t settings[NUM_PHASES];
    sb = new();
    full_rate = 1'b0;
    settings_used = 0;
    sequences_closed = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_sample = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset length of three: extremes, equal values, a falling run.
    send_sample(swm_pkg::sample_t'(-32768), 1'b0);
    send_sample(swm_pkg::sample_t'(32767), 1'b0);
    send_sample(swm_pkg::sample_t'(0), 1'b0);
    send_sample(swm_pkg::sample_t'(-1), 1'b0);
    send_sample(swm_pkg::sample_t'(32767), 1'b0);
    send_sample(swm_pkg::sample_t'(5), 1'b0);
    send_sample(swm_pkg::sample_t'(5), 1'b0);
    send_sample(swm_pkg::sample_t'(5), 1'b0);
    send_sample(swm_pkg::sample_t'(100), 1'b0);
    send_sample(swm_pkg::sample_t'(90), 1'b0);
    send_sample(swm_pkg::sample_t'(80), 1'b0);
    send_sample(swm_pkg::sample_t'(70), 1'b0);
    send_sample(swm_pkg::sample_t'(-32768), 1'b1);
    // Sequences that end before the window has filled.
    send_sample(swm_pkg::sample_t'(7), 1'b0);
    send_sample(swm_pkg::sample_t'(8), 1'b1);
    send_sample(swm_pkg::sample_t'(1), 1'b1);
    // A length of zero acts as a window of one.
    write_window(swm_pkg::len_t'(0));
    send_sample(swm_pkg::sample_t'(-5), 1'b0);
    send_sample(swm_pkg::sample_t'(32767), 1'b0);
    send_sample(swm_pkg::sample_t'(-32768), 1'b1);

    // The phase at 31 stops mid-sequence, so the next one shrinks a live window.
    settings = '{swm_pkg::len_t'(16), swm_pkg::len_t'(31), swm_pkg::len_t'(2),
                 swm_pkg::len_t'(17), swm_pkg::len_t'(1), swm_pkg::len_t'(5),
                 swm_pkg::len_t'(0), swm_pkg::len_t'(9), swm_pkg::len_t'(16),
                 swm_pkg::len_t'(4), swm_pkg::len_t'(0), swm_pkg::len_t'(0)};
    settings[10] = swm_pkg::len_t'($urandom_range(1, 31));
    settings[11] = swm_pkg::len_t'($urandom_range(1, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(settings[p]);
      full_rate = ($urandom_range(0, 3) == 0);
      run_phase(PHASE_ITEMS, p % 3 != 1, p == 0);
    end
    full_rate = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d samples in %0d closed sequences over %0d window settings.",
             sb.samples_noted, sequences_closed, settings_used + 1);
    $display("%0d window results checked, with stalls and a live length change.",
             sb.results_checked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
